// File: src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared types and constants for the hsv to rgb colour conversion pipeline
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_W      = 10;
	localparam int PCT_W      = 7;
	localparam int CHAN_W     = 8;
	localparam int HUE_RED_W  = 9;
	localparam int REM_W      = 6;
	localparam int TERM_W     = 13;
	localparam int FRAC_W     = 20;
	localparam int NUM_W      = 24;
	localparam int RECIP_W    = 25;
	localparam int PROD_W     = NUM_W + RECIP_W;

	localparam int HUE_FULL_TURN = 360;
	localparam int HUE_SECTOR    = 60;
	localparam int PERCENT_MAX   = 100;
	localparam int SECTOR_FULL   = PERCENT_MAX * HUE_SECTOR;

	// x * 255 / 600000 == x * 17 / 40000, the divide by 40000 done by reciprocal
	localparam int CHAN_NUM_MUL  = 17;
	localparam int DIV_SHIFT     = 40;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd27487791;

	typedef enum logic [2:0] {
		SECTOR_RED_YELLOW    = 3'd0,
		SECTOR_YELLOW_GREEN  = 3'd1,
		SECTOR_GREEN_CYAN    = 3'd2,
		SECTOR_CYAN_BLUE     = 3'd3,
		SECTOR_BLUE_MAGENTA  = 3'd4,
		SECTOR_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t            sector;
		logic [REM_W-1:0]   rem;
		logic [PCT_W-1:0]   sat;
		logic [PCT_W-1:0]   val;
	} sector_item_t;

	typedef struct packed {
		sector_t             sector;
		logic [FRAC_W-1:0]   v;
		logic [FRAC_W-1:0]   p;
		logic [FRAC_W-1:0]   q;
		logic [FRAC_W-1:0]   t;
	} terms_item_t;

endpackage

// File: src/hsv_to_rgb_converter.sv
// throughput: one item per cycle while the output is not stalled, six register stages with a valid bit each
// a stall at the output holds each full stage with no empty stage after it, empty stages still fill
// reset clears the valid bits only, no data registers are reset
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// hsv (hue in degrees, saturation and brightness in percent) to 8-bit rgb
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hsv_valid,
	output logic                           hsv_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_angle,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]  brightness,
	output logic                           rgb_valid,
	input  logic                           rgb_ready,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] blue
);
	import hsv2rgb_pkg::*;

	logic          sect_valid, sect_ready;
	sector_item_t  sect_item;
	logic          terms_valid, terms_ready;
	terms_item_t   terms_item;

	hsv2rgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (hsv_valid),
		.in_ready   (hsv_ready),
		.hue_angle  (hue_angle),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (sect_valid),
		.out_ready  (sect_ready),
		.out_item   (sect_item)
	);

	hsv2rgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sect_valid),
		.in_ready  (sect_ready),
		.in_item   (sect_item),
		.out_valid (terms_valid),
		.out_ready (terms_ready),
		.out_item  (terms_item)
	);

	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (terms_valid),
		.in_ready  (terms_ready),
		.in_item   (terms_item),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// an empty output stage lets the whole pipe move
	a_ready_when_drained : assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> hsv_ready)
		else $error("input stalled while output stage empty");

	a_remainder_range : assert property (@(posedge clk) disable iff (!arst_n)
		sect_valid |-> (sect_item.rem < REM_W'(HUE_SECTOR)))
		else $error("hue remainder out of sector");

	a_value_dominates : assert property (@(posedge clk) disable iff (!arst_n)
		terms_valid |-> (terms_item.v >= terms_item.p && terms_item.v >= terms_item.q
			&& terms_item.v >= terms_item.t))
		else $error("v term below p, q or t");

	a_value_bounded : assert property (@(posedge clk) disable iff (!arst_n)
		terms_valid |-> (terms_item.v <= FRAC_W'(PERCENT_MAX * SECTOR_FULL)))
		else $error("v term above full scale");

endmodule

// File: src/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// clamps the percentages, reduces the hue modulo 360 and splits it into
// a 60 degree sector and a remainder, two register stages
// ----------------------------------------------------------------------------
module hsv2rgb_sector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_angle,
	input  logic [hsv2rgb_pkg::PCT_W-1:0] saturation,
	input  logic [hsv2rgb_pkg::PCT_W-1:0] brightness,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hsv2rgb_pkg::sector_item_t   out_item
);
	import hsv2rgb_pkg::*;

	localparam logic [HUE_W-1:0] ONE_TURN  = HUE_W'(HUE_FULL_TURN);
	localparam logic [HUE_W-1:0] TWO_TURNS = HUE_W'(2 * HUE_FULL_TURN);
	localparam logic [PCT_W-1:0] PCT_MAX   = PCT_W'(PERCENT_MAX);
	localparam logic [HUE_RED_W-1:0] SEC1  = HUE_RED_W'(HUE_SECTOR);
	localparam logic [HUE_RED_W-1:0] SEC2  = HUE_RED_W'(2 * HUE_SECTOR);
	localparam logic [HUE_RED_W-1:0] SEC3  = HUE_RED_W'(3 * HUE_SECTOR);
	localparam logic [HUE_RED_W-1:0] SEC4  = HUE_RED_W'(4 * HUE_SECTOR);
	localparam logic [HUE_RED_W-1:0] SEC5  = HUE_RED_W'(5 * HUE_SECTOR);

	logic                  valid_s1, valid_s2;
	logic                  en_s1, en_s2;
	logic [HUE_RED_W-1:0]  hue_s1;
	logic [PCT_W-1:0]      sat_s1, val_s1;
	logic [HUE_RED_W-1:0]  hue_red;
	logic [HUE_RED_W-1:0]  sec_base;
	sector_t               sector;
	sector_item_t          item_s2;

	assign en_s2     = !valid_s2 || out_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	always_comb begin
		if (hue_angle >= TWO_TURNS) begin
			hue_red = HUE_RED_W'(hue_angle - TWO_TURNS);
		end else if (hue_angle >= ONE_TURN) begin
			hue_red = HUE_RED_W'(hue_angle - ONE_TURN);
		end else begin
			hue_red = HUE_RED_W'(hue_angle);
		end
	end

	always_comb begin
		if (hue_s1 >= SEC5) begin
			sector   = SECTOR_MAGENTA_RED;
			sec_base = SEC5;
		end else if (hue_s1 >= SEC4) begin
			sector   = SECTOR_BLUE_MAGENTA;
			sec_base = SEC4;
		end else if (hue_s1 >= SEC3) begin
			sector   = SECTOR_CYAN_BLUE;
			sec_base = SEC3;
		end else if (hue_s1 >= SEC2) begin
			sector   = SECTOR_GREEN_CYAN;
			sec_base = SEC2;
		end else if (hue_s1 >= SEC1) begin
			sector   = SECTOR_YELLOW_GREEN;
			sec_base = SEC1;
		end else begin
			sector   = SECTOR_RED_YELLOW;
			sec_base = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			hue_s1 <= hue_red;
			sat_s1 <= (saturation > PCT_MAX) ? PCT_MAX : saturation;
			val_s1 <= (brightness > PCT_MAX) ? PCT_MAX : brightness;
		end
		if (en_s2 && valid_s1) begin
			item_s2.sector <= sector;
			item_s2.rem    <= REM_W'(hue_s1 - sec_base);
			item_s2.sat    <= sat_s1;
			item_s2.val    <= val_s1;
		end
	end

endmodule

// File: src/hsv2rgb_terms.sv
// ----------------------------------------------------------------------------
// hsv2rgb_terms
// forms the v, p, q and t fractions over the denominator 600000,
// two register stages
// ----------------------------------------------------------------------------
module hsv2rgb_terms (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hsv2rgb_pkg::sector_item_t in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output hsv2rgb_pkg::terms_item_t  out_item
);
	import hsv2rgb_pkg::*;

	localparam logic [TERM_W-1:0] FULL     = TERM_W'(SECTOR_FULL);
	localparam logic [REM_W-1:0]  SEC_SPAN = REM_W'(HUE_SECTOR);
	localparam logic [PCT_W-1:0]  PCT_MAX  = PCT_W'(PERCENT_MAX);

	logic               valid_s3, valid_s4;
	logic               en_s3, en_s4;
	sector_t            sector_s3;
	logic [PCT_W-1:0]   val_s3;
	logic [TERM_W-1:0]  pm_s3, qm_s3, tm_s3;
	logic [TERM_W-1:0]  sat_rem, sat_comp, pm;
	logic [REM_W-1:0]   rem_comp;
	terms_item_t        item_s4;

	assign en_s4     = !valid_s4 || out_ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign in_ready  = en_s3;
	assign out_valid = valid_s4;
	assign out_item  = item_s4;

	always_comb begin
		rem_comp = SEC_SPAN - in_item.rem;
		sat_rem  = TERM_W'(in_item.sat) * TERM_W'(in_item.rem);
		sat_comp = TERM_W'(in_item.sat) * TERM_W'(rem_comp);
		pm       = TERM_W'(PCT_MAX - in_item.sat) * TERM_W'(HUE_SECTOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= in_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			sector_s3 <= in_item.sector;
			val_s3    <= in_item.val;
			pm_s3     <= pm;
			qm_s3     <= FULL - sat_rem;
			tm_s3     <= FULL - sat_comp;
		end
		if (en_s4 && valid_s3) begin
			item_s4.sector <= sector_s3;
			item_s4.v      <= FRAC_W'(val_s3) * FRAC_W'(FULL);
			item_s4.p      <= FRAC_W'(val_s3) * FRAC_W'(pm_s3);
			item_s4.q      <= FRAC_W'(val_s3) * FRAC_W'(qm_s3);
			item_s4.t      <= FRAC_W'(val_s3) * FRAC_W'(tm_s3);
		end
	end

endmodule

// File: src/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// routes the terms to the channels by sector and scales each fraction to
// 0..255 with a reciprocal multiply, two register stages
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  hsv2rgb_pkg::terms_item_t     in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0] blue
);
	import hsv2rgb_pkg::*;

	logic               valid_s5, valid_s6;
	logic               en_s5, en_s6;
	logic [FRAC_W-1:0]  rc, gc, bc;
	logic [NUM_W-1:0]   rn_s5, gn_s5, bn_s5;
	logic [PROD_W-1:0]  rprod, gprod, bprod;
	logic [CHAN_W-1:0]  red_s6, green_s6, blue_s6;

	assign en_s6     = !valid_s6 || out_ready;
	assign en_s5     = !valid_s5 || en_s6;
	assign in_ready  = en_s5;
	assign out_valid = valid_s6;
	assign red       = red_s6;
	assign green     = green_s6;
	assign blue      = blue_s6;

	always_comb begin
		case (in_item.sector)
			SECTOR_RED_YELLOW: begin
				rc = in_item.v; gc = in_item.t; bc = in_item.p;
			end
			SECTOR_YELLOW_GREEN: begin
				rc = in_item.q; gc = in_item.v; bc = in_item.p;
			end
			SECTOR_GREEN_CYAN: begin
				rc = in_item.p; gc = in_item.v; bc = in_item.t;
			end
			SECTOR_CYAN_BLUE: begin
				rc = in_item.p; gc = in_item.q; bc = in_item.v;
			end
			SECTOR_BLUE_MAGENTA: begin
				rc = in_item.t; gc = in_item.p; bc = in_item.v;
			end
			default: begin
				rc = in_item.v; gc = in_item.p; bc = in_item.q;
			end
		endcase
	end

	always_comb begin
		rprod = PROD_W'(rn_s5) * PROD_W'(DIV_RECIP);
		gprod = PROD_W'(gn_s5) * PROD_W'(DIV_RECIP);
		bprod = PROD_W'(bn_s5) * PROD_W'(DIV_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s5) begin
				valid_s5 <= in_valid;
			end
			if (en_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && in_valid) begin
			rn_s5 <= NUM_W'(rc) * NUM_W'(CHAN_NUM_MUL);
			gn_s5 <= NUM_W'(gc) * NUM_W'(CHAN_NUM_MUL);
			bn_s5 <= NUM_W'(bc) * NUM_W'(CHAN_NUM_MUL);
		end
		if (en_s6 && valid_s5) begin
			red_s6   <= rprod[DIV_SHIFT +: CHAN_W];
			green_s6 <= gprod[DIV_SHIFT +: CHAN_W];
			blue_s6  <= bprod[DIV_SHIFT +: CHAN_W];
		end
	end

endmodule

// File: tb/hsv_to_rgb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// watches both channels of the converter, works out the rgb colour of each
// accepted hsv item in exact integer arithmetic and compares every rgb item,
// in order, with the oldest colour still owed
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hsv_valid,
	input  logic                           hsv_ready,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_angle,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::PCT_W-1:0]  brightness,
	input  logic                           rgb_valid,
	input  logic                           rgb_ready,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] blue,
	output int                             colours_owed,
	output int                             mismatch_count
);
	import hsv2rgb_pkg::*;

	localparam int unsigned CHAN_FULL = 255;
	localparam int unsigned FRAC_DEN  = 600000;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} colour_t;

	colour_t owed_colours[$];

	initial begin
		mismatch_count = 0;
		colours_owed = 0;
	end

	function automatic logic [CHAN_W-1:0] frac_to_chan(input int unsigned frac);
		int unsigned scaled;
		scaled = (frac * CHAN_FULL) / FRAC_DEN;
		return scaled[CHAN_W-1:0];
	endfunction

	function automatic colour_t hsv_colour(input logic [HUE_W-1:0] hue,
			input logic [PCT_W-1:0] sat_in, input logic [PCT_W-1:0] val_in);
		int unsigned sat, val, deg, rem;
		int unsigned term_v, term_p, term_q, term_t;
		sector_t     sector;
		colour_t     colour;
		sat = (sat_in > PERCENT_MAX) ? PERCENT_MAX : sat_in;
		val = (val_in > PERCENT_MAX) ? PERCENT_MAX : val_in;
		deg = hue % HUE_FULL_TURN;
		sector = sector_t'(deg / HUE_SECTOR);
		rem = deg % HUE_SECTOR;
		term_v = val * SECTOR_FULL;
		term_p = val * (PERCENT_MAX - sat) * HUE_SECTOR;
		term_q = val * (SECTOR_FULL - sat * rem);
		term_t = val * (SECTOR_FULL - sat * (HUE_SECTOR - rem));
		case (sector)
			SECTOR_RED_YELLOW: begin
				colour = {frac_to_chan(term_v), frac_to_chan(term_t), frac_to_chan(term_p)};
			end
			SECTOR_YELLOW_GREEN: begin
				colour = {frac_to_chan(term_q), frac_to_chan(term_v), frac_to_chan(term_p)};
			end
			SECTOR_GREEN_CYAN: begin
				colour = {frac_to_chan(term_p), frac_to_chan(term_v), frac_to_chan(term_t)};
			end
			SECTOR_CYAN_BLUE: begin
				colour = {frac_to_chan(term_p), frac_to_chan(term_q), frac_to_chan(term_v)};
			end
			SECTOR_BLUE_MAGENTA: begin
				colour = {frac_to_chan(term_t), frac_to_chan(term_p), frac_to_chan(term_v)};
			end
			default: begin
				colour = {frac_to_chan(term_v), frac_to_chan(term_p), frac_to_chan(term_q)};
			end
		endcase
		return colour;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t: rgb mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		colour_t want;
		if (arst_n) begin
			if (rgb_valid && rgb_ready) begin
				if (owed_colours.size() == 0) begin
					report_mismatch("unexpected item", 0, 1);
				end else begin
					want = owed_colours.pop_front();
					if (red !== want.red) begin
						report_mismatch("red", want.red, red);
					end
					if (green !== want.green) begin
						report_mismatch("green", want.green, green);
					end
					if (blue !== want.blue) begin
						report_mismatch("blue", want.blue, blue);
					end
				end
			end
			if (hsv_valid && hsv_ready) begin
				owed_colours.push_back(hsv_colour(hue_angle, saturation, brightness));
			end
		end
		colours_owed = owed_colours.size();
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives hsv items into the converter under random gaps and output stalls,
// with a long output hold-off to back the pipeline up; the checker beside
// the converter predicts and compares every rgb item
// ----------------------------------------------------------------------------
module tb;

	import hsv2rgb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 12;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              hsv_valid = 1'b0;
	logic              hsv_ready;
	logic [HUE_W-1:0]  hue_angle = '0;
	logic [PCT_W-1:0]  saturation = '0;
	logic [PCT_W-1:0]  brightness = '0;
	logic              rgb_valid;
	logic              rgb_ready = 1'b0;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	int colours_owed;
	int mismatch_count;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	bit hold_request = 1'b0;
	int cycle_count = 0;

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue_angle  (hue_angle),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	hsv_to_rgb_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.hsv_valid      (hsv_valid),
		.hsv_ready      (hsv_ready),
		.hue_angle      (hue_angle),
		.saturation     (saturation),
		.brightness     (brightness),
		.rgb_valid      (rgb_valid),
		.rgb_ready      (rgb_ready),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.colours_owed   (colours_owed),
		.mismatch_count (mismatch_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side, with an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rgb_ready <= 1'b0;
		end else begin
			rgb_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter test failed");
			$finish;
		end
	end

	task automatic offer_hsv(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
			input logic [PCT_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			hsv_valid <= 1'b0;
			@(posedge clk);
		end
		hsv_valid <= 1'b1;
		hue_angle <= hue;
		saturation <= sat;
		brightness <= val;
		do @(posedge clk); while (!hsv_ready);
	endtask

	task automatic offer_random_hsv();
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] val;
		hue = HUE_W'($urandom_range(1023));
		sat = PCT_W'($urandom_range(127));
		val = PCT_W'($urandom_range(127));
		if ($urandom_range(4) == 0) begin
			hue = HUE_W'(HUE_SECTOR * $urandom_range(17));
		end
		if ($urandom_range(5) == 0) begin
			sat = PCT_W'(PERCENT_MAX);
		end
		if ($urandom_range(5) == 0) begin
			val = PCT_W'(PERCENT_MAX);
		end
		offer_hsv(hue, sat, val);
	endtask

	initial begin
		int phase_items[3];
		phase_items = '{400, 400, 300};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 68;

		// sector edges, hue wrap, saturation and brightness limits
		offer_hsv(10'd0, 7'd100, 7'd100);
		offer_hsv(10'd59, 7'd100, 7'd100);
		offer_hsv(10'd60, 7'd100, 7'd100);
		offer_hsv(10'd119, 7'd100, 7'd100);
		offer_hsv(10'd120, 7'd100, 7'd100);
		offer_hsv(10'd180, 7'd100, 7'd100);
		offer_hsv(10'd240, 7'd100, 7'd100);
		offer_hsv(10'd300, 7'd100, 7'd100);
		offer_hsv(10'd330, 7'd50, 7'd100);
		offer_hsv(10'd359, 7'd100, 7'd100);
		offer_hsv(10'd360, 7'd100, 7'd100);
		offer_hsv(10'd719, 7'd75, 7'd60);
		offer_hsv(10'd720, 7'd100, 7'd100);
		offer_hsv(10'd1023, 7'd127, 7'd127);
		offer_hsv(10'd200, 7'd0, 7'd100);
		offer_hsv(10'd200, 7'd0, 7'd0);
		offer_hsv(10'd200, 7'd100, 7'd0);
		offer_hsv(10'd90, 7'd101, 7'd101);
		offer_hsv(10'd270, 7'd127, 7'd100);
		offer_hsv(10'd45, 7'd100, 7'd127);
		offer_hsv(10'd150, 7'd1, 7'd1);
		offer_hsv(10'd512, 7'd64, 7'd64);
		offer_hsv(10'd30, 7'd33, 7'd99);
		offer_hsv(10'd210, 7'd99, 7'd33);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < phase_items[phase]; n++) begin
				if (phase == 2 && (n == 50 || n == 200)) begin
					hold_request = 1'b1;
				end
				offer_random_hsv();
			end
		end
		hsv_valid <= 1'b0;

		@(posedge clk);
		while (colours_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("hsv_to_rgb_converter test passed");
		end else begin
			$display("hsv_to_rgb_converter test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
src/hsv2rgb_pkg.sv
src/hsv2rgb_sector.sv
src/hsv2rgb_terms.sv
src/hsv2rgb_scale.sv
src/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_checker.sv
tb/tb.sv
